FILE: rtl/tdfsm_pkg.sv
// Shared types and codes for the table-driven state machine engine.
`timescale 1ns / 1ps

package tdfsm_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned ST_W    = 8;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 8;
  localparam int unsigned TENT_W  = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_TRANS  = 3'd0,
    CMD_LOAD_ACTION = 3'd1,
    CMD_EVENT       = 3'd2,
    CMD_PERFORM     = 3'd3,
    CMD_RESTART     = 3'd4
  } cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_RUN     = 3'd1,
    ACT_SWITCH  = 3'd2,
    ACT_FAIL    = 3'd3,
    ACT_NO_SLOT = 3'd4
  } act_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_TRANS_COUNT  = 2'd0,
    CFG_ACTION_COUNT = 2'd1,
    CFG_START_STATE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_T_ADDR,
    ST_T_CHK,
    ST_A_ADDR,
    ST_A_CHK,
    ST_FIN
  } st_e;

endpackage

FILE: rtl/tdfsm_tables.sv
// Transition and action table memories, one write and one registered read port each.
`timescale 1ns / 1ps

module tdfsm_tables
  import tdfsm_pkg::*;
#(
  parameter int unsigned TRANSITION_DEPTH = 16,
  parameter int unsigned ACTION_DEPTH     = 16,
  parameter int unsigned TAW              = 4,
  parameter int unsigned AAW              = 4
) (
  input  logic              clk_i,
  input  logic              t_we_i,
  input  logic [TAW-1:0]    t_waddr_i,
  input  logic [TENT_W-1:0] t_wdata_i,
  input  logic [TAW-1:0]    t_raddr_i,
  output logic [TENT_W-1:0] t_rdata_o,
  input  logic              a_we_i,
  input  logic [AAW-1:0]    a_waddr_i,
  input  logic [ST_W-1:0]   a_wdata_i,
  input  logic [AAW-1:0]    a_raddr_i,
  output logic [ST_W-1:0]   a_rdata_o
);

  logic [TENT_W-1:0] t_mem [TRANSITION_DEPTH];
  logic [ST_W-1:0]   a_mem [ACTION_DEPTH];
  logic [TENT_W-1:0] t_rdata_q;
  logic [ST_W-1:0]   a_rdata_q;

  always_ff @(posedge clk_i) begin
    if (t_we_i) begin
      t_mem[t_waddr_i] <= t_wdata_i;
    end
    t_rdata_q <= t_mem[t_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (a_we_i) begin
      a_mem[a_waddr_i] <= a_wdata_i;
    end
    a_rdata_q <= a_mem[a_raddr_i];
  end

  assign t_rdata_o = t_rdata_q;
  assign a_rdata_o = a_rdata_q;

endmodule

FILE: rtl/table_driven_fsm_engine_unit.sv
// Top level of the table-driven state machine engine.
`timescale 1ns / 1ps

// Programmable table-driven state machine. Commands load the transition
// table (event, from state, to state) and the action table (state id per
// slot), post events, perform pending transitions or restart at start_state.
// Every accepted command yields exactly one result transfer carrying the
// action code, the exit/running slot, the enter slot, the current state and
// the pending flag. One command is processed at a time: in_stall_o is high
// from acceptance until the result is loaded into the output register, and
// a new command may be accepted while that result still waits on out_stall_i.
// An event visits transition entries in order, at most transition_count of
// them clamped to the table depth; a perform visits action entries in one
// or two slot searches. A search that runs out of entries without a match
// ends with a final limit check. Each visited entry takes a registered memory
// read and a compare in the shared 16-bit comparator. Table contents are not
// cleared at reset: searching an entry that was never loaded gives an
// undefined result.
module table_driven_fsm_engine_unit
  import tdfsm_pkg::*;
#(
  parameter int unsigned TRANSITION_DEPTH = 16,
  parameter int unsigned ACTION_DEPTH     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [CFG_D_W-1:0] cfg_data_i,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [IDX_W-1:0]   entry_index_i,
  input  logic [ST_W-1:0]    event_id_i,
  input  logic [ST_W-1:0]    from_state_i,
  input  logic [ST_W-1:0]    to_state_i,
  input  logic [ST_W-1:0]    action_state_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ACT_W-1:0]   action_o,
  output logic [SLOT_W-1:0]  first_slot_o,
  output logic [SLOT_W-1:0]  second_slot_o,
  output logic [ST_W-1:0]    current_state_o,
  output logic               pending_o
);

  localparam int unsigned TAW  = (TRANSITION_DEPTH > 1) ? $clog2(TRANSITION_DEPTH) : 1;
  localparam int unsigned AAW  = (ACTION_DEPTH > 1) ? $clog2(ACTION_DEPTH) : 1;
  localparam int unsigned MAXD = (TRANSITION_DEPTH > ACTION_DEPTH) ?
                                 TRANSITION_DEPTH : ACTION_DEPTH;
  localparam int unsigned CW   = $clog2(MAXD + 1);

  // configuration
  logic [CNT_W-1:0] cfg_tcnt_q, cfg_acnt_q;
  logic [ST_W-1:0]  cfg_start_q;

  // sequencer and latched command
  st_e              state_q, state_d;
  cmd_e             cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic [ST_W-1:0]  ev_q, from_q, to_q, ast_q;
  logic [CW-1:0]    k_q, k_d;
  logic             phase_q, phase_d;

  // engine state
  logic [ST_W-1:0]  state_now_q, state_now_d;
  logic [ST_W-1:0]  state_next_q, state_next_d;
  logic             pending_q, pending_d;

  // result being built
  act_e              res_act_q, res_act_d;
  logic [SLOT_W-1:0] res_s1_q, res_s1_d, res_s2_q, res_s2_d;

  // output register
  logic              out_valid_q, out_valid_d;
  act_e              out_act_q;
  logic [SLOT_W-1:0] out_s1_q, out_s2_q;
  logic [ST_W-1:0]   out_state_q;
  logic              out_pend_q;

  logic [CW-1:0]     tlim, alim;
  logic              in_acc, out_free;
  logic              t_we, a_we;
  logic [TENT_W-1:0] t_rdata;
  logic [ST_W-1:0]   a_rdata;
  logic [ST_W-1:0]   key;
  logic [15:0]       cmp_a, cmp_b;
  logic              cmp_eq;

  // search limits: count clamped to table depth
  always_comb begin
    if (32'(cfg_tcnt_q) > TRANSITION_DEPTH) begin
      tlim = CW'(TRANSITION_DEPTH);
    end else begin
      tlim = CW'(cfg_tcnt_q);
    end
    if (32'(cfg_acnt_q) > ACTION_DEPTH) begin
      alim = CW'(ACTION_DEPTH);
    end else begin
      alim = CW'(cfg_acnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tcnt_q  <= '0;
      cfg_acnt_q  <= '0;
      cfg_start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TRANS_COUNT:  cfg_tcnt_q  <= cfg_data_i[CNT_W-1:0];
        CFG_ACTION_COUNT: cfg_acnt_q  <= cfg_data_i[CNT_W-1:0];
        CFG_START_STATE:  cfg_start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_e'(command_i);
      idx_q  <= entry_index_i;
      ev_q   <= event_id_i;
      from_q <= from_state_i;
      to_q   <= to_state_i;
      ast_q  <= action_state_i;
    end
  end

  // loads happen in dispatch; out-of-range indexes are dropped
  assign t_we = (state_q == ST_DISP) && (cmd_q == CMD_LOAD_TRANS) &&
                (32'(idx_q) < TRANSITION_DEPTH);
  assign a_we = (state_q == ST_DISP) && (cmd_q == CMD_LOAD_ACTION) &&
                (32'(idx_q) < ACTION_DEPTH);

  tdfsm_tables #(
    .TRANSITION_DEPTH (TRANSITION_DEPTH),
    .ACTION_DEPTH     (ACTION_DEPTH),
    .TAW              (TAW),
    .AAW              (AAW)
  ) u_tables (
    .clk_i     (clk_i),
    .t_we_i    (t_we),
    .t_waddr_i (TAW'(idx_q)),
    .t_wdata_i ({ev_q, from_q, to_q}),
    .t_raddr_i (k_q[TAW-1:0]),
    .t_rdata_o (t_rdata),
    .a_we_i    (a_we),
    .a_waddr_i (AAW'(idx_q)),
    .a_wdata_i (ast_q),
    .a_raddr_i (k_q[AAW-1:0]),
    .a_rdata_o (a_rdata)
  );

  // single shared comparator: {event, from} for transitions, state id for slots
  assign key = phase_q ? state_next_q : state_now_q;
  always_comb begin
    if (state_q == ST_T_CHK) begin
      cmp_a = {t_rdata[23:16], t_rdata[15:8]};
      cmp_b = {ev_q, state_now_q};
    end else begin
      cmp_a = {8'h00, a_rdata};
      cmp_b = {8'h00, key};
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      phase_q      <= 1'b0;
      state_now_q  <= '0;
      state_next_q <= '0;
      pending_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      phase_q      <= phase_d;
      state_now_q  <= state_now_d;
      state_next_q <= state_next_d;
      pending_q    <= pending_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_act_q <= res_act_d;
    res_s1_q  <= res_s1_d;
    res_s2_q  <= res_s2_d;
    if (state_q == ST_FIN && out_free) begin
      out_act_q   <= res_act_q;
      out_s1_q    <= res_s1_q;
      out_s2_q    <= res_s2_q;
      out_state_q <= state_now_q;
      out_pend_q  <= pending_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    phase_d      = phase_q;
    state_now_d  = state_now_q;
    state_next_d = state_next_q;
    pending_d    = pending_q;
    res_act_d    = res_act_q;
    res_s1_d     = res_s1_q;
    res_s2_d     = res_s2_q;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d   = ST_DISP;
          k_d       = '0;
          phase_d   = 1'b0;
          res_act_d = ACT_NONE;
          res_s1_d  = '0;
          res_s2_d  = '0;
        end
      end
      ST_DISP: begin
        unique case (cmd_q)
          CMD_EVENT:   state_d = ST_T_ADDR;
          CMD_PERFORM: state_d = ST_A_ADDR;
          CMD_RESTART: begin
            state_now_d  = cfg_start_q;
            state_next_d = '0;
            pending_d    = 1'b0;
            state_d      = ST_FIN;
          end
          default:     state_d = ST_FIN;
        endcase
      end
      ST_T_ADDR: begin
        // no match leaves pending untouched
        state_d = (k_q == tlim) ? ST_FIN : ST_T_CHK;
      end
      ST_T_CHK: begin
        if (cmp_eq) begin
          state_next_d = t_rdata[7:0];
          pending_d    = 1'b1;
          state_d      = ST_FIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_T_ADDR;
        end
      end
      ST_A_ADDR: begin
        if (k_q == alim) begin
          // slot search missed
          if (pending_q) begin
            res_act_d = ACT_FAIL;
            res_s1_d  = '0;
            pending_d = 1'b0;
          end else begin
            res_act_d = ACT_NO_SLOT;
          end
          state_d = ST_FIN;
        end else begin
          state_d = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (cmp_eq) begin
          if (!pending_q) begin
            res_act_d = ACT_RUN;
            res_s1_d  = SLOT_W'(k_q);
            state_d   = ST_FIN;
          end else if (!phase_q) begin
            // exit slot found, now look up the enter slot
            res_s1_d = SLOT_W'(k_q);
            phase_d  = 1'b1;
            k_d      = '0;
            state_d  = ST_A_ADDR;
          end else begin
            res_act_d    = ACT_SWITCH;
            res_s2_d     = SLOT_W'(k_q);
            state_now_d  = state_next_q;
            state_next_d = 8'hFF;
            pending_d    = 1'b0;
            state_d      = ST_FIN;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_A_ADDR;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_act_q;
  assign first_slot_o    = out_s1_q;
  assign second_slot_o   = out_s2_q;
  assign current_state_o = out_state_q;
  assign pending_o       = out_pend_q;

`ifndef SYNTHESIS
  // a completed or failed transition always drops pending
  a_switch_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_SWITCH || action_o == ACT_FAIL) |-> !pending_o)
    else $error("pending set after perform of a transition");

  // enter slot only carries meaning for a switch
  a_second_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o != ACT_SWITCH) |-> (second_slot_o == '0))
    else $error("second slot nonzero without a switch");

  // scan never reads past the configured limit
  a_tscan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_T_CHK) |-> (k_q < tlim))
    else $error("transition scan beyond limit");

  a_ascan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A_CHK) |-> (k_q < alim))
    else $error("action scan beyond limit");
`endif

endmodule

FILE: tb/sv/table_driven_fsm_engine_unit_tb.sv
// Self-checking testbench for the table-driven state machine engine.
`timescale 1ns / 1ps

// Stimulus:
//   - a directed table walked by one loop: reset values, unknown commands,
//     loads at slot extremes, event hit/miss/replace, switch, fail, run,
//     no-slot and restart; register rows drain the engine before a write
//   - five random phases; each refills both tables from a small alphabet of
//     states and events (so events hit and switches happen), then mixes
//     events, performs, loads, restarts and raw noise commands
// Checking: an in-order model of the engine runs on every accepted command
// transfer; result transfers are compared field by field, oldest first.
// Flow control: random idle bursts on both channels, one long result
// hold-off so the engine backs up into its command channel, and a final
// phase with no idling at all.
module table_driven_fsm_engine_unit_tb;
  import tdfsm_pkg::*;

  localparam int TABLE_DEPTH     = 16;
  localparam int NUM_STATES      = 5;
  localparam int NUM_EVENTS      = 3;
  localparam int NUM_PHASES      = 5;
  localparam int PRESSURE_PHASE  = 2;
  localparam int CMDS_PER_PHASE  = 100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  // Covers ~700 commands with worst-case engine searches and idle bursts on
  // both channels, plus the hold-off and drains, with ample margin.
  localparam int CYCLE_LIMIT     = 500000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  idx;
    logic [ST_W-1:0]   ev;
    logic [ST_W-1:0]   from_st;
    logic [ST_W-1:0]   to_st;
    logic [ST_W-1:0]   act_st;
  } fsm_cmd_t;

  typedef struct packed {
    act_e              action;
    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] second_slot;
    logic [ST_W-1:0]   state;
    logic              pending;
  } fsm_report_t;

  // directed row: either a register setting or one command, optionally with
  // a hand-written expected report
  typedef struct {
    bit                is_cfg;
    logic [CNT_W-1:0]  trans_cnt;
    logic [CNT_W-1:0]  action_cnt;
    logic [ST_W-1:0]   start;
    fsm_cmd_t          c;
    bit                typed;
    fsm_report_t       r;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_A_W-1:0] cfg_index_i;
  logic [CFG_D_W-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CMD_W-1:0]   command_i;
  logic [IDX_W-1:0]   entry_index_i;
  logic [ST_W-1:0]    event_id_i;
  logic [ST_W-1:0]    from_state_i;
  logic [ST_W-1:0]    to_state_i;
  logic [ST_W-1:0]    action_state_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ACT_W-1:0]   action_o;
  logic [SLOT_W-1:0]  first_slot_o;
  logic [SLOT_W-1:0]  second_slot_o;
  logic [ST_W-1:0]    current_state_o;
  logic               pending_o;

  table_driven_fsm_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .event_id_i      (event_id_i),
    .from_state_i    (from_state_i),
    .to_state_i      (to_state_i),
    .action_state_i  (action_state_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .first_slot_o    (first_slot_o),
    .second_slot_o   (second_slot_o),
    .current_state_o (current_state_o),
    .pending_o       (pending_o)
  );

  // ---------------------------------------------------------------------
  // Engine model: tables, state and register copies, reset values.
  // Tables start at zero here, but stimulus never reads an unloaded entry.
  // ---------------------------------------------------------------------
  logic [TENT_W-1:0] trans_rows   [TABLE_DEPTH];
  logic [ST_W-1:0]   action_slots [TABLE_DEPTH];
  logic [ST_W-1:0]   cur_state      = '0;
  logic [ST_W-1:0]   next_state     = '0;
  logic              switch_pending = 1'b0;
  logic [CNT_W-1:0]  trans_count    = '0;
  logic [CNT_W-1:0]  action_count   = '0;
  logic [ST_W-1:0]   restart_state  = '0;

  fsm_report_t reports_due [$];
  fsm_report_t predicted;
  fsm_report_t want;
  int          fail_count = 0;
  int          cycles_run = 0;

  // stimulus control shared with the idle processes
  bit          quiet         = 1'b0;
  bit          hold_off_req  = 1'b0;
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  bit          typed_pending = 1'b0;
  fsm_report_t typed_result;

  logic [ST_W-1:0] alpha_st [NUM_STATES];
  logic [ST_W-1:0] alpha_ev [NUM_EVENTS];

  function automatic fsm_cmd_t cmd_of(input logic [CMD_W-1:0] cmd,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [ST_W-1:0] ev,
                                      input logic [ST_W-1:0] from_st,
                                      input logic [ST_W-1:0] to_st,
                                      input logic [ST_W-1:0] act_st);
    fsm_cmd_t c;
    c.cmd     = cmd;
    c.idx     = idx;
    c.ev      = ev;
    c.from_st = from_st;
    c.to_st   = to_st;
    c.act_st  = act_st;
    return c;
  endfunction

  function automatic fsm_report_t report_of(input act_e a,
                                            input logic [SLOT_W-1:0] s1,
                                            input logic [SLOT_W-1:0] s2,
                                            input logic [ST_W-1:0] st,
                                            input logic pend);
    fsm_report_t r;
    r.action      = a;
    r.first_slot  = s1;
    r.second_slot = s2;
    r.state       = st;
    r.pending     = pend;
    return r;
  endfunction

  // in-order search of the first action_count slots (clamped to depth)
  function automatic bit slot_lookup(input logic [ST_W-1:0] st,
                                     output logic [SLOT_W-1:0] slot);
    int lim;
    lim = (action_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(action_count);
    slot = '0;
    for (int k = 0; k < lim; k++) begin
      if (action_slots[k] == st) begin
        slot = SLOT_W'(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // advance the model by one command and return the report it produces
  function automatic fsm_report_t fsm_step(input fsm_cmd_t c);
    fsm_report_t r;
    int lim;
    logic [SLOT_W-1:0] exit_slot, enter_slot;
    bit have_exit, have_enter;
    r = '0;
    r.action = ACT_NONE;
    case (c.cmd)
      CMD_LOAD_TRANS: trans_rows[c.idx] = {c.ev, c.from_st, c.to_st};
      CMD_LOAD_ACTION: action_slots[c.idx] = c.act_st;
      CMD_EVENT: begin
        lim = (trans_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(trans_count);
        for (int k = 0; k < lim; k++) begin
          if (trans_rows[k][23:16] == c.ev && trans_rows[k][15:8] == cur_state) begin
            next_state = trans_rows[k][7:0];
            switch_pending = 1'b1;
            break;
          end
        end
      end
      CMD_PERFORM: begin
        if (switch_pending) begin
          have_exit  = slot_lookup(cur_state, exit_slot);
          have_enter = slot_lookup(next_state, enter_slot);
          if (have_exit && have_enter) begin
            r.action      = ACT_SWITCH;
            r.first_slot  = exit_slot;
            r.second_slot = enter_slot;
            cur_state     = next_state;
            next_state    = 8'hFF;
          end else begin
            r.action = ACT_FAIL;
          end
          switch_pending = 1'b0;
        end else if (slot_lookup(cur_state, exit_slot)) begin
          r.action     = ACT_RUN;
          r.first_slot = exit_slot;
        end else begin
          r.action = ACT_NO_SLOT;
        end
      end
      CMD_RESTART: begin
        cur_state      = restart_state;
        next_state     = '0;
        switch_pending = 1'b0;
      end
      default: ;
    endcase
    r.state   = cur_state;
    r.pending = switch_pending;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // mostly alphabet values so tables and events line up; some raw bytes
  function automatic logic [ST_W-1:0] pick_state();
    if ($urandom_range(0, 9) == 0) return ST_W'($urandom);
    return alpha_st[$urandom_range(0, NUM_STATES - 1)];
  endfunction

  function automatic logic [ST_W-1:0] pick_event();
    if ($urandom_range(0, 9) == 0) return ST_W'($urandom);
    return alpha_ev[$urandom_range(0, NUM_EVENTS - 1)];
  endfunction

  function automatic fsm_cmd_t random_command();
    fsm_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c = cmd_of(CMD_EVENT, IDX_W'($urandom), pick_event(), pick_state(),
               pick_state(), pick_state());
    if (roll < 35) c.cmd = CMD_EVENT;
    else if (roll < 65) c.cmd = CMD_PERFORM;
    else if (roll < 73) c.cmd = CMD_LOAD_TRANS;
    else if (roll < 80) c.cmd = CMD_LOAD_ACTION;
    else if (roll < 88) c.cmd = CMD_RESTART;
    else begin
      // noise: any opcode, unknown ones included, with raw field values
      c = cmd_of(CMD_W'($urandom_range(0, 7)), IDX_W'($urandom), ST_W'($urandom),
                 ST_W'($urandom), ST_W'($urandom), ST_W'($urandom));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, and the cycle limit that ends a hung run
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("** table_driven_fsm_engine_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Command transfers: the model runs at the edge that accepts a command.
  // Directed rows with a hand-written report push that one instead.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted = fsm_step(cmd_of(command_i, entry_index_i, event_id_i, from_state_i,
                                  to_state_i, action_state_i));
      if (typed_pending) predicted = typed_result;
      reports_due.push_back(predicted);
    end
  end

  // Result transfers: compare with the oldest outstanding report.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reports_due.size() == 0) begin
        $error("result transfer with nothing outstanding: action=%0d state=%0d",
               action_o, current_state_o);
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("action", want.action, action_o);
        check_field("first_slot", want.first_slot, first_slot_o);
        check_field("second_slot", want.second_slot, second_slot_o);
        check_field("current_state", want.state, current_state_o);
        check_field("pending", want.pending, pending_o);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, or one long hold-off on request.
  // The hold-off is counted here while the sender keeps offering commands.
  // ---------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_stall_i  = 1'b0;
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Command side. Tasks start and end on a falling edge; payload holds
  // while stalled, valid stays high across back-to-back transfers.
  // ---------------------------------------------------------------------
  task automatic issue_command(input fsm_cmd_t c, input bit typed, input fsm_report_t r);
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    command_i      = c.cmd;
    entry_index_i  = c.idx;
    event_id_i     = c.ev;
    from_state_i   = c.from_st;
    to_state_i     = c.to_st;
    action_state_i = c.act_st;
    typed_pending  = typed;
    typed_result   = r;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // registers change only with nothing in flight
  task automatic wait_until_idle();
    in_valid_i = 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [CNT_W-1:0] tc, input logic [CNT_W-1:0] ac,
                              input logic [ST_W-1:0] start);
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_TRANS_COUNT;
    cfg_data_i  = CFG_D_W'(tc);
    @(posedge clk_i);
    trans_count = tc;
    @(negedge clk_i);
    cfg_index_i = CFG_ACTION_COUNT;
    cfg_data_i  = CFG_D_W'(ac);
    @(posedge clk_i);
    action_count = ac;
    @(negedge clk_i);
    cfg_index_i = CFG_START_STATE;
    cfg_data_i  = start;
    @(posedge clk_i);
    restart_state = start;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  dir_row_t dir_rows [$];

  function automatic void add_cfg(input logic [CNT_W-1:0] tc, input logic [CNT_W-1:0] ac,
                                  input logic [ST_W-1:0] start);
    dir_row_t row;
    row.is_cfg     = 1'b1;
    row.trans_cnt  = tc;
    row.action_cnt = ac;
    row.start      = start;
    row.c          = '0;
    row.typed      = 1'b0;
    row.r          = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cmd(input fsm_cmd_t c, input bit typed, input fsm_report_t r);
    dir_row_t row;
    row.is_cfg     = 1'b0;
    row.trans_cnt  = '0;
    row.action_cnt = '0;
    row.start      = '0;
    row.c          = c;
    row.typed      = typed;
    row.r          = r;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [CNT_W-1:0] tc, ac;
    logic [ST_W-1:0]  start;
    int               drop;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_TRANS_COUNT;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    command_i      = CMD_LOAD_TRANS;
    entry_index_i  = '0;
    event_id_i     = '0;
    from_state_i   = '0;
    to_state_i     = '0;
    action_state_i = '0;
    typed_result   = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      trans_rows[k]   = '0;
      action_slots[k] = '0;
    end

    // Directed part. Counts stay zero first: event and perform read no entry.
    add_cfg(5'd0, 5'd0, 8'hFF);
    add_cmd(cmd_of(CMD_EVENT, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_NONE, 0, 0, 8'h00, 1'b0));
    // nothing loaded, nothing searched: no slot for the current state
    add_cmd(cmd_of(CMD_PERFORM, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_NO_SLOT, 0, 0, 8'h00, 1'b0));
    add_cmd(cmd_of(CMD_RESTART, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    // unknown opcodes, all-ones and all-zeros payloads
    add_cmd(cmd_of(3'd5, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    add_cmd(cmd_of(3'd7, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    add_cmd(cmd_of(CMD_LOAD_TRANS, 4'd0, 8'hFF, 8'hFF, 8'h00, 8'h00), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    add_cmd(cmd_of(CMD_LOAD_TRANS, 4'd15, 8'h00, 8'h00, 8'hFF, 8'h00), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    add_cmd(cmd_of(CMD_LOAD_ACTION, 4'd0, 8'h00, 8'h00, 8'h00, 8'hFF), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    add_cmd(cmd_of(CMD_LOAD_ACTION, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    add_cmd(cmd_of(CMD_LOAD_ACTION, 4'd15, 8'h00, 8'h00, 8'h00, 8'hAA), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    // search one transition and two action slots, all loaded above
    add_cfg(5'd1, 5'd2, 8'hFF);
    // event that matches nothing leaves pending clear
    add_cmd(cmd_of(CMD_EVENT, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b0));
    add_cmd(cmd_of(CMD_EVENT, 4'd0, 8'hFF, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_NONE, 0, 0, 8'hFF, 1'b1));
    // 0xFF -> 0x00: exit slot 0, enter slot 1
    add_cmd(cmd_of(CMD_PERFORM, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_SWITCH, 4'd0, 4'd1, 8'h00, 1'b0));
    add_cmd(cmd_of(CMD_PERFORM, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_RUN, 4'd1, 0, 8'h00, 1'b0));
    // event while pending: a later match replaces the pending target
    add_cmd(cmd_of(CMD_LOAD_TRANS, 4'd0, 8'h01, 8'h00, 8'h77, 8'h00), 0, '0);
    add_cmd(cmd_of(CMD_EVENT, 4'd0, 8'h01, 8'h00, 8'h00, 8'h00), 0, '0);
    add_cmd(cmd_of(CMD_LOAD_TRANS, 4'd0, 8'h01, 8'h00, 8'hFF, 8'h00), 0, '0);
    add_cmd(cmd_of(CMD_EVENT, 4'd0, 8'h01, 8'h00, 8'h00, 8'h00), 0, '0);
    add_cmd(cmd_of(CMD_PERFORM, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);
    // target with no action slot: transition fails, state kept
    add_cmd(cmd_of(CMD_LOAD_TRANS, 4'd0, 8'h02, 8'hFF, 8'h77, 8'h00), 0, '0);
    add_cmd(cmd_of(CMD_EVENT, 4'd0, 8'h02, 8'h00, 8'h00, 8'h00), 0, '0);
    add_cmd(cmd_of(CMD_PERFORM, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
            report_of(ACT_FAIL, 0, 0, 8'hFF, 1'b0));
    add_cmd(cmd_of(CMD_RESTART, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);
    add_cmd(cmd_of(CMD_PERFORM, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_until_idle();
        program_regs(dir_rows[i].trans_cnt, dir_rows[i].action_cnt, dir_rows[i].start);
      end else begin
        issue_command(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
      end
    end
    typed_pending = 1'b0;

    // Random phases: new alphabet and register setting, table refill, mix.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_until_idle();
      for (int k = 0; k < NUM_STATES; k++) alpha_st[k] = ST_W'($urandom);
      for (int k = 0; k < NUM_EVENTS; k++) alpha_ev[k] = ST_W'($urandom);
      case (p)
        0: begin
          tc = 5'd16;
          ac = 5'd16;
          tx_idle_pct = 25;
          rx_idle_pct = 25;
        end
        1: begin
          // byte extremes as states and events, counts above the depth
          alpha_st[0] = 8'hFF;
          alpha_st[1] = 8'h00;
          alpha_ev[0] = 8'h00;
          alpha_ev[1] = 8'hFF;
          tc = 5'd31;
          ac = 5'd31;
          tx_idle_pct = 45;
          rx_idle_pct = 45;
        end
        PRESSURE_PHASE: begin
          tc = CNT_W'($urandom_range(1, 15));
          ac = CNT_W'($urandom_range(1, 15));
          tx_idle_pct = 0;
          rx_idle_pct = 10;
        end
        3: begin
          alpha_st[0] = 8'h00;
          tc = CNT_W'($urandom_range(0, 31));
          ac = CNT_W'($urandom_range(0, 31));
          tx_idle_pct = 10;
          rx_idle_pct = 35;
        end
        default: begin
          tc = 5'd16;
          ac = 5'd16;
          quiet = 1'b1;
        end
      endcase
      start = alpha_st[0];
      program_regs(tc, ac, start);
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;

      // Fill every entry so no search can reach an unloaded one. A coin toss in
      // each phase decides whether the restart state is left out of the action table.
      drop = $urandom_range(0, 1);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        issue_command(cmd_of(CMD_LOAD_TRANS, IDX_W'(k),
                             alpha_ev[$urandom_range(0, NUM_EVENTS - 1)],
                             alpha_st[$urandom_range(0, NUM_STATES - 1)],
                             alpha_st[$urandom_range(0, NUM_STATES - 1)], 8'h00), 0, '0);
      end
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        issue_command(cmd_of(CMD_LOAD_ACTION, IDX_W'(k), 8'h00, 8'h00, 8'h00,
                             alpha_st[$urandom_range(drop, NUM_STATES - 1)]), 0, '0);
      end
      for (int n = 0; n < CMDS_PER_PHASE; n++) issue_command(random_command(), 0, '0);
    end

    // Drain, then allow for any stray late transfer.
    in_valid_i = 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && reports_due.size() == 0) begin
      $display("** table_driven_fsm_engine_unit: PASSED **");
    end else begin
      $display("** table_driven_fsm_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tdfsm_pkg.sv
rtl/tdfsm_tables.sv
rtl/table_driven_fsm_engine_unit.sv
tb/sv/table_driven_fsm_engine_unit_tb.sv
